@@ sv/ndsi_pkg.sv @@
// shared types, constants and helpers for the numa domain select iterator
`timescale 1ns / 1ps
package ndsi_pkg;

  localparam int DOM_W      = 3;
  localparam int MASK_W     = 8;
  localparam int ORDER_W    = 24;
  localparam int COUNT_W    = 4;
  localparam int PAGE_W     = 40;
  localparam int BIAS_W     = 32;
  localparam int ROT_W      = 32;
  localparam int OFFSET_W   = 42;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 24;
  localparam int KIND_W     = 2;
  localparam int POLICY_W   = 2;

  localparam int IN_TDATA_W  = 88;
  localparam int OUT_TDATA_W = 8;

  localparam int DEF_MAX_DOMAINS  = 8;
  localparam int DEF_STRIDE_SHIFT = 6;

  localparam logic [COUNT_W-1:0] COUNT_MIN = 4'd1;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 4'd8;

  localparam logic [CFG_ADDR_W-1:0] REG_POLICY    = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_VALID     = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_ORDER     = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_COUNT     = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_PREFERRED = 3'd4;

  typedef enum logic [KIND_W-1:0] {
    KIND_START   = 2'd0,
    KIND_RESTART = 2'd1,
    KIND_NEXT    = 2'd2,
    KIND_IGNORE  = 2'd3
  } kind_t;

  typedef enum logic [POLICY_W-1:0] {
    POL_FIRST_TOUCH = 2'd0,
    POL_ROUND_ROBIN = 2'd1,
    POL_PREFERRED   = 2'd2,
    POL_INTERLEAVE  = 2'd3
  } policy_t;

  typedef struct packed {
    logic in_ready;
    logic apply;
    logic mod_start;
    logic begin_search;
    logic try_start;
    logic try_walk;
    logic walk_clr;
    logic phase2;
    logic emit;
    logic emit_found;
  } ndsi_cmd_t;

  typedef struct packed {
    logic  in_fire;
    kind_t kind;
    logic  mod_done;
    logic  take;
    logic  walk_end;
    logic  skip_low;
    logic  out_free;
  } ndsi_sts_t;

  function automatic logic [DOM_W-1:0] table_entry(input logic [ORDER_W-1:0] tbl,
                                                   input logic [DOM_W-1:0] idx);
    return tbl[DOM_W*idx +: DOM_W];
  endfunction

endpackage

@@ sv/ndsi_mod.sv @@
// multi-cycle remainder unit, eight dividend bits per cycle, small divisor
`timescale 1ns / 1ps
module ndsi_mod
  import ndsi_pkg::*;
#(
  parameter int W = OFFSET_W
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [W-1:0]       value,
  input  logic [COUNT_W-1:0] div,
  output logic [DOM_W-1:0]   rem,
  output logic               done
);

  localparam int STEPS = (W + 7) / 8;
  localparam int DW    = STEPS * 8;
  localparam int CW    = (STEPS > 1) ? $clog2(STEPS) : 1;
  localparam logic [CW-1:0] LAST = CW'(STEPS - 1);

  logic [DW-1:0]    sh;
  logic [CW-1:0]    cnt;
  logic             busy;
  logic [DOM_W-1:0] rem_next;

  always_comb begin
    logic [DOM_W-1:0]   r;
    logic [COUNT_W-1:0] t;
    r = rem;
    for (int j = 0; j < 8; j++) begin
      t = {r, sh[DW-1-j]};
      if (t >= div) begin
        t = t - div;
      end
      r = t[DOM_W-1:0];
    end
    rem_next = r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        sh   <= DW'(value);
        rem  <= '0;
      end else if (busy) begin
        sh  <= sh << 8;
        rem <= rem_next;
        cnt <= cnt + 1'b1;
        if (cnt == LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  a_rem_below_div: assert property (@(posedge clk) disable iff (rst)
    done |-> ({1'b0, rem} < div))
    else $error("remainder not below divisor");

endmodule

@@ sv/ndsi_dpath.sv @@
// datapath: configuration, search masks, rotation, candidate test and result register
`timescale 1ns / 1ps
module ndsi_dpath
  import ndsi_pkg::*;
#(
  parameter int MAX_DOMAINS  = DEF_MAX_DOMAINS,
  parameter int STRIDE_SHIFT = DEF_STRIDE_SHIFT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  input  kind_t                 in_kind,
  input  logic [PAGE_W-1:0]     in_page_index,
  input  logic [BIAS_W-1:0]     in_object_bias,
  input  logic [MASK_W-1:0]     in_low_mask,
  input  logic [DOM_W-1:0]      in_cpu_domain,
  input  logic [DOM_W-1:0]      in_ignore_domain,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_found,
  output logic [DOM_W-1:0]      out_domain,
  input  ndsi_cmd_t             cmd,
  output ndsi_sts_t             sts
);

  policy_t            policy;
  logic [MASK_W-1:0]  valid_mask;
  logic [ORDER_W-1:0] order_table;
  logic [COUNT_W-1:0] domain_count;
  logic [DOM_W-1:0]   preferred_domain;

  logic [MASK_W-1:0]   active_mask;
  logic [MASK_W-1:0]   remain_mask;
  logic [MASK_W-1:0]   deferred_mask;
  logic                skip_low;
  logic [ROT_W-1:0]    rotate_counter;
  logic [OFFSET_W-1:0] interleave_offset;

  kind_t               item_kind;
  logic [PAGE_W-1:0]   item_page;
  logic [BIAS_W-1:0]   item_bias;
  logic [MASK_W-1:0]   item_low;
  logic [DOM_W-1:0]    item_cpu;
  logic [DOM_W-1:0]    item_ignore;

  logic [DOM_W-1:0]    rot_idx;
  logic [DOM_W-1:0]    off_idx;
  logic [COUNT_W-1:0]  walk_cnt;
  logic [DOM_W-1:0]    res_domain;

  logic [COUNT_W-1:0]  n;
  logic [OFFSET_W-1:0] offset_new;
  logic [OFFSET_W-1:0] offset_mod_in;
  logic                set_offset;
  logic [DOM_W-1:0]    start_cand;
  logic [DOM_W-1:0]    cand;
  logic [MASK_W-1:0]   cand_bit;
  logic                hit;
  logic                take;
  logic                fetch;
  logic [DOM_W-1:0]    rot_rem;
  logic [DOM_W-1:0]    off_rem;
  logic                rot_done;
  logic                off_done;
  logic                in_fire;
  logic                out_free;

  function automatic logic [MASK_W-1:0] dom_bit(input logic [DOM_W-1:0] d);
    if (32'(d) < MAX_DOMAINS) begin
      return MASK_W'(1) << d;
    end
    return '0;
  endfunction

  always_comb begin
    if (domain_count == '0) begin
      n = COUNT_MIN;
    end else if (domain_count > COUNT_MAX) begin
      n = COUNT_MAX;
    end else begin
      n = domain_count;
    end
  end

  assign offset_new    = OFFSET_W'(item_page >> STRIDE_SHIFT) + OFFSET_W'(item_bias);
  assign set_offset    = cmd.apply && item_kind == KIND_START && policy == POL_INTERLEAVE;
  assign offset_mod_in = set_offset ? offset_new : interleave_offset;

  always_comb begin
    unique case (policy)
      POL_FIRST_TOUCH: start_cand = item_cpu;
      POL_ROUND_ROBIN: start_cand = table_entry(order_table, rot_idx);
      POL_PREFERRED:   start_cand = preferred_domain;
      POL_INTERLEAVE:  start_cand = table_entry(order_table, off_idx);
      default:         start_cand = item_cpu;
    endcase
  end

  assign cand     = cmd.try_start ? start_cand : table_entry(order_table, rot_idx);
  assign cand_bit = dom_bit(cand);
  assign hit      = |(remain_mask & cand_bit);
  assign take     = hit && (!skip_low || !(|(item_low & cand_bit)));
  assign fetch    = (cmd.try_start && policy == POL_ROUND_ROBIN) || cmd.try_walk;

  assign in_fire  = in_valid && cmd.in_ready;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    sts.in_fire  = in_fire;
    sts.kind     = item_kind;
    sts.mod_done = rot_done;
    sts.take     = take;
    sts.walk_end = (walk_cnt >= n) || (remain_mask == '0);
    sts.skip_low = skip_low;
    sts.out_free = out_free;
  end

  ndsi_mod #(.W(OFFSET_W)) u_rot_mod (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.mod_start),
    .value (OFFSET_W'(rotate_counter)),
    .div   (n),
    .rem   (rot_rem),
    .done  (rot_done)
  );

  ndsi_mod #(.W(OFFSET_W)) u_off_mod (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.mod_start),
    .value (offset_mod_in),
    .div   (n),
    .rem   (off_rem),
    .done  (off_done)
  );

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      policy           <= POL_FIRST_TOUCH;
      valid_mask       <= MASK_W'(1);
      order_table      <= '0;
      domain_count     <= COUNT_MIN;
      preferred_domain <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_POLICY:    policy           <= policy_t'(cfg_wdata[POLICY_W-1:0]);
        REG_VALID:     valid_mask       <= cfg_wdata[MASK_W-1:0];
        REG_ORDER:     order_table      <= cfg_wdata[ORDER_W-1:0];
        REG_COUNT:     domain_count     <= cfg_wdata[COUNT_W-1:0];
        REG_PREFERRED: preferred_domain <= cfg_wdata[DOM_W-1:0];
        default: ;
      endcase
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_kind   <= in_kind;
      item_page   <= in_page_index;
      item_bias   <= in_object_bias;
      item_low    <= in_low_mask;
      item_cpu    <= in_cpu_domain;
      item_ignore <= in_ignore_domain;
    end
  end

  // search state
  always_ff @(posedge clk) begin
    if (rst) begin
      active_mask       <= '0;
      remain_mask       <= '0;
      deferred_mask     <= '0;
      skip_low          <= 1'b1;
      rotate_counter    <= '0;
      interleave_offset <= '0;
    end else begin
      if (cmd.apply) begin
        if (item_kind == KIND_START) begin
          active_mask <= valid_mask;
        end else if (item_kind == KIND_IGNORE) begin
          active_mask <= active_mask & ~dom_bit(item_ignore);
        end
      end
      if (set_offset) begin
        interleave_offset <= offset_new;
      end
      if (cmd.begin_search) begin
        remain_mask   <= active_mask;
        deferred_mask <= '0;
        skip_low      <= 1'b1;
      end else if (cmd.phase2) begin
        remain_mask <= deferred_mask;
        skip_low    <= 1'b0;
      end else if (cmd.try_start || cmd.try_walk) begin
        if (hit) begin
          remain_mask <= remain_mask & ~cand_bit;
        end
        if (hit && !take) begin
          deferred_mask <= deferred_mask | cand_bit;
        end
      end
      if (fetch) begin
        rotate_counter <= rotate_counter + 1'b1;
      end
    end
  end

  // indices and walk bound; the counter wrapping to zero restarts the index too
  always_ff @(posedge clk) begin
    if (rot_done) begin
      rot_idx <= rot_rem;
      off_idx <= off_rem;
    end else if (fetch) begin
      rot_idx <= (({1'b0, rot_idx} + 1'b1 == n) || (&rotate_counter)) ? '0 : rot_idx + 1'b1;
    end
    if (cmd.walk_clr) begin
      walk_cnt <= '0;
    end else if (cmd.try_walk) begin
      walk_cnt <= walk_cnt + 1'b1;
    end
    if ((cmd.try_start || cmd.try_walk) && take) begin
      res_domain <= cand;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_found  <= cmd.emit_found;
      out_domain <= cmd.emit_found ? res_domain : '0;
    end
  end

  a_phase1_disjoint: assert property (@(posedge clk) disable iff (rst)
    skip_low |-> ((remain_mask & deferred_mask) == '0))
    else $error("deferred domain still pending in phase one");

  a_mod_lanes_agree: assert property (@(posedge clk) disable iff (rst)
    rot_done == off_done)
    else $error("remainder lanes out of step");

  a_rot_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.try_walk |-> ({1'b0, rot_idx} < n))
    else $error("rotation index beyond domain count");

endmodule

@@ sv/ndsi_ctrl.sv @@
// controller: sequences apply, remainder, first candidate, two walk phases and result
`timescale 1ns / 1ps
module ndsi_ctrl
  import ndsi_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  ndsi_sts_t sts,
  output ndsi_cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_APPLY,
    ST_MOD,
    ST_BEGIN,
    ST_START,
    ST_WALK,
    ST_SWITCH,
    ST_DONE
  } state_t;

  state_t state;
  state_t state_next;
  logic   found;
  logic   found_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    found_next = found;
    unique case (state)
      ST_IDLE: begin
        cmd.in_ready = 1'b1;
        if (sts.in_fire) begin
          state_next = ST_APPLY;
        end
      end
      ST_APPLY: begin
        cmd.apply = 1'b1;
        if (sts.kind == KIND_IGNORE) begin
          state_next = ST_IDLE;
        end else begin
          cmd.mod_start = 1'b1;
          state_next    = ST_MOD;
        end
      end
      ST_MOD: begin
        if (sts.mod_done) begin
          if (sts.kind == KIND_NEXT) begin
            cmd.walk_clr = 1'b1;
            state_next   = ST_WALK;
          end else begin
            state_next = ST_BEGIN;
          end
        end
      end
      ST_BEGIN: begin
        cmd.begin_search = 1'b1;
        state_next       = ST_START;
      end
      ST_START: begin
        cmd.try_start = 1'b1;
        if (sts.take) begin
          found_next = 1'b1;
          state_next = ST_DONE;
        end else begin
          cmd.walk_clr = 1'b1;
          state_next   = ST_WALK;
        end
      end
      ST_WALK: begin
        if (sts.walk_end) begin
          if (sts.skip_low) begin
            state_next = ST_SWITCH;
          end else begin
            found_next = 1'b0;
            state_next = ST_DONE;
          end
        end else begin
          cmd.try_walk = 1'b1;
          if (sts.take) begin
            found_next = 1'b1;
            state_next = ST_DONE;
          end
        end
      end
      ST_SWITCH: begin
        cmd.phase2 = 1'b1;
        state_next = ST_START;
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.emit       = 1'b1;
          cmd.emit_found = found;
          state_next     = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      found <= 1'b0;
    end else begin
      state <= state_next;
      found <= found_next;
    end
  end

  a_take_to_done: assert property (@(posedge clk) disable iff (rst)
    (state == ST_START && sts.take) |=> (state == ST_DONE && found))
    else $error("accepted candidate not reported");

  a_done_to_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && sts.out_free) |=> state == ST_IDLE)
    else $error("result not handed over");

  a_ignore_no_result: assert property (@(posedge clk) disable iff (rst)
    (state == ST_APPLY && sts.kind == KIND_IGNORE) |=> state == ST_IDLE)
    else $error("ignore request did not return to idle");

endmodule

@@ sv/numa_domain_select_iterator.sv @@
// top level of the numa domain select iterator
`timescale 1ns / 1ps
// Picks the memory domain for a page allocation, one request at a time. A
// request is taken only while the block is idle; a finished result sits in an
// output register, so the next request may start before the result is taken.
// An ignore request gives no result. Every other request is applied, then
// the remainder unit reduces the rotation counter and the interleave offset
// modulo the domain count (six steps of 8 bits over 42 bits, then the
// remainders are handed over), then candidates are tried, one per cycle:
// the policy's first candidate (not in phase one of a next request) and up
// to count round-robin candidates in each of the two phases, with a state
// to close each walk, a state to enter each phase and one to load the result.
module numa_domain_select_iterator
  import ndsi_pkg::*;
#(
  parameter int MAX_DOMAINS  = DEF_MAX_DOMAINS,
  parameter int STRIDE_SHIFT = DEF_STRIDE_SHIFT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // page_index, object_bias, low_mask, cpu_domain, ignore_domain, zero fill
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  // kind
  input  logic [KIND_W-1:0]      s_tuser,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // domain, zero fill
  output logic [OUT_TDATA_W-1:0] m_tdata,
  // found
  output logic                   m_tuser
);

  localparam int BIAS_LSB   = PAGE_W;
  localparam int LOW_LSB    = BIAS_LSB + BIAS_W;
  localparam int CPU_LSB    = LOW_LSB + MASK_W;
  localparam int IGNORE_LSB = CPU_LSB + DOM_W;

  ndsi_cmd_t        cmd;
  ndsi_sts_t        sts;
  logic [DOM_W-1:0] out_domain;

  ndsi_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  ndsi_dpath #(
    .MAX_DOMAINS  (MAX_DOMAINS),
    .STRIDE_SHIFT (STRIDE_SHIFT)
  ) u_dpath (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_addr         (cfg_addr),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (s_tvalid),
    .in_kind          (kind_t'(s_tuser)),
    .in_page_index    (s_tdata[PAGE_W-1:0]),
    .in_object_bias   (s_tdata[BIAS_LSB +: BIAS_W]),
    .in_low_mask      (s_tdata[LOW_LSB +: MASK_W]),
    .in_cpu_domain    (s_tdata[CPU_LSB +: DOM_W]),
    .in_ignore_domain (s_tdata[IGNORE_LSB +: DOM_W]),
    .out_valid        (m_tvalid),
    .out_ready        (m_tready),
    .out_found        (m_tuser),
    .out_domain       (out_domain),
    .cmd              (cmd),
    .sts              (sts)
  );

  assign s_tready = cmd.in_ready;
  assign m_tdata  = OUT_TDATA_W'(out_domain);

endmodule
